>>> rtl/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg: shared types and constants of the indexed deque
// Opcodes, status codes, the command item passed from front to back, and
// circular-store address helpers.
// ----------------------------------------------------------------------------
package idq_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam int IN_BITS  = OPCODE_W + VALUE_W + POS_W;
	localparam int IN_W     = 8 * ((IN_BITS + 7) / 8);
	localparam int OUT_BITS = DATA_W + COUNT_W + STATUS_W;
	localparam int OUT_W    = 8 * ((OUT_BITS + 7) / 8);

	localparam logic [DATA_W-1:0] ERR_WORD = '1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_PEEK_FRONT = 3'd3,
		OP_PEEK_BACK  = 3'd4,
		OP_READ_AT    = 3'd5,
		OP_REMOVE_AT  = 3'd6,
		OP_REVERSE    = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_REV_A,
		S_REV_B
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
	} cmd_t;

	// Physical address of the entry at offset off from the front.
	function automatic logic [ADDR_W-1:0] slot_f(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (ADDR_W + 1)'(DEPTH)) begin
			s = s - (ADDR_W + 1)'(DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] dec_f(input logic [ADDR_W-1:0] a);
		return (a == '0) ? ADDR_W'(DEPTH - 1) : a - ADDR_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] inc_f(input logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
	endfunction

endpackage

>>> rtl/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram: generic RAM
// One write port and two read ports, each read registered and held while
// its read enable is low.
// ----------------------------------------------------------------------------
module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic                     re_b,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> rtl/idq_front.sv
// ----------------------------------------------------------------------------
// idq_front: request intake
// Takes request items, decodes the opcode and holds them in a two-entry
// queue until the back end is ready for them.
// ----------------------------------------------------------------------------
module idq_front
	import idq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  logic            cmd_pop
);

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.op       = op_t'(s_tdata[OPCODE_W-1:0]);
		in_cmd.value    = s_tdata[OPCODE_W +: VALUE_W];
		in_cmd.position = s_tdata[OPCODE_W + VALUE_W +: POS_W];
	end

	assign s_tready  = (fill_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

>>> rtl/idq_back.sv
// ----------------------------------------------------------------------------
// idq_back: deque execution
// Owns the circular store, its front pointer and count, runs each request
// to completion and holds its result in the output register.
// ----------------------------------------------------------------------------
module idq_back
	import idq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   front_q, front_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [ADDR_W-1:0]   idx_q, idx_d;
	logic [ADDR_W-1:0]   a_q, a_d;
	logic [ADDR_W-1:0]   b_q, b_d;

	logic                res_valid_q;
	logic [DATA_W-1:0]   res_data_q;
	logic [CNT_W-1:0]    res_count_q;
	status_t             res_status_q;
	logic                res_load;
	logic [DATA_W-1:0]   res_data_d;
	status_t             res_status_d;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic                ram_re_a, ram_re_b;
	logic [ADDR_W-1:0]   ram_raddr_a, ram_raddr_b;
	logic [DATA_W-1:0]   ram_rdata_a, ram_rdata_b;

	logic                out_free;
	logic [CNT_W-1:0]    pos_c;
	logic [CNT_W-1:0]    idx_w;
	logic [CNT_W-1:0]    half;

	idq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re_a   (ram_re_a),
		.raddr_a(ram_raddr_a),
		.rdata_a(ram_rdata_a),
		.re_b   (ram_re_b),
		.raddr_b(ram_raddr_b),
		.rdata_b(ram_rdata_b)
	);

	assign out_free = !res_valid_q || m_tready;
	assign pos_c    = CNT_W'(cmd.position);
	assign idx_w    = CNT_W'(idx_q);
	assign half     = count_q >> 1;

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		idx_d        = idx_q;
		a_d          = a_q;
		b_d          = b_q;
		cmd_pop      = 1'b0;
		res_load     = 1'b0;
		res_data_d   = '0;
		res_status_d = ST_OK;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = cmd.value;
		ram_re_a     = 1'b0;
		ram_re_b     = 1'b0;
		ram_raddr_a  = front_q;
		ram_raddr_b  = front_q;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_load     = 1'b1;
								res_data_d   = ERR_WORD;
								res_status_d = ST_FULL;
							end else begin
								ram_we = 1'b1;
								if (cmd.op == OP_PUSH_FRONT) begin
									front_d   = dec_f(front_q);
									ram_waddr = dec_f(front_q);
								end else begin
									ram_waddr = slot_f(front_q, ADDR_W'(count_q));
								end
								count_d  = count_q + CNT_W'(1);
								res_load = 1'b1;
							end
						end
						OP_POP_FRONT, OP_PEEK_FRONT, OP_PEEK_BACK: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_data_d   = ERR_WORD;
								res_status_d = ST_EMPTY;
							end else begin
								ram_re_a = 1'b1;
								state_d  = S_READ;
								if (cmd.op == OP_PEEK_BACK) begin
									ram_raddr_a = slot_f(front_q,
										ADDR_W'(count_q - CNT_W'(1)));
								end
								if (cmd.op == OP_POP_FRONT) begin
									front_d = inc_f(front_q);
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						OP_READ_AT: begin
							if (pos_c >= count_q) begin
								res_load     = 1'b1;
								res_data_d   = ERR_WORD;
								res_status_d = ST_RANGE;
							end else begin
								ram_re_a    = 1'b1;
								ram_raddr_a = slot_f(front_q, ADDR_W'(pos_c));
								state_d     = S_READ;
							end
						end
						OP_REMOVE_AT: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_data_d   = ERR_WORD;
								res_status_d = ST_EMPTY;
							end else if (pos_c >= count_q) begin
								res_load     = 1'b1;
								res_data_d   = ERR_WORD;
								res_status_d = ST_RANGE;
							end else if ((pos_c + CNT_W'(1)) < count_q) begin
								ram_re_a    = 1'b1;
								ram_raddr_a = slot_f(front_q, ADDR_W'(pos_c + CNT_W'(1)));
								idx_d       = ADDR_W'(pos_c);
								state_d     = S_SHIFT;
							end else begin
								// Removing the back word needs no moves.
								count_d  = count_q - CNT_W'(1);
								res_load = 1'b1;
								if (count_q == CNT_W'(1)) begin
									front_d = '0;
								end
							end
						end
						OP_REVERSE: begin
							if (count_q < CNT_W'(2)) begin
								res_load = 1'b1;
							end else begin
								a_d         = front_q;
								b_d         = slot_f(front_q, ADDR_W'(count_q - CNT_W'(1)));
								ram_re_a    = 1'b1;
								ram_re_b    = 1'b1;
								ram_raddr_a = front_q;
								ram_raddr_b = slot_f(front_q, ADDR_W'(count_q - CNT_W'(1)));
								idx_d       = '0;
								state_d     = S_REV_A;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				res_load   = 1'b1;
				res_data_d = ram_rdata_a;
				state_d    = S_IDLE;
			end
			S_SHIFT: begin
				// Move the word one place toward the front, fetching the next.
				ram_we    = 1'b1;
				ram_waddr = slot_f(front_q, idx_q);
				ram_wdata = ram_rdata_a;
				if (({1'b0, idx_w} + (CNT_W + 1)'(2)) < {1'b0, count_q}) begin
					ram_re_a    = 1'b1;
					ram_raddr_a = slot_f(front_q, ADDR_W'(idx_w + CNT_W'(2)));
					idx_d       = idx_q + ADDR_W'(1);
				end else begin
					count_d  = count_q - CNT_W'(1);
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_REV_A: begin
				ram_we    = 1'b1;
				ram_waddr = a_q;
				ram_wdata = ram_rdata_b;
				state_d   = S_REV_B;
			end
			S_REV_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_q;
				ram_wdata = ram_rdata_a;
				if ((idx_w + CNT_W'(1)) < half) begin
					a_d         = slot_f(front_q, ADDR_W'(idx_w + CNT_W'(1)));
					b_d         = slot_f(front_q, ADDR_W'(count_q - CNT_W'(2) - idx_w));
					ram_re_a    = 1'b1;
					ram_re_b    = 1'b1;
					ram_raddr_a = slot_f(front_q, ADDR_W'(idx_w + CNT_W'(1)));
					ram_raddr_b = slot_f(front_q, ADDR_W'(count_q - CNT_W'(2) - idx_w));
					idx_d       = idx_q + ADDR_W'(1);
					state_d     = S_REV_A;
				end else begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		a_q   <= a_d;
		b_q   <= b_d;
		if (res_load) begin
			res_data_q   <= res_data_d;
			res_count_q  <= count_d;
			res_status_q <= res_status_d;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {(OUT_W - OUT_BITS)'(0), res_status_q, COUNT_W'(res_count_q), res_data_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("word count exceeds the store depth");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !res_valid_q)
		else $error("result pending while a multi-cycle request runs");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && (cmd.op == OP_PUSH_BACK || cmd.op == OP_PUSH_FRONT)
			&& count_q == CNT_W'(DEPTH))
		|=> (count_q == CNT_W'(DEPTH) && res_valid_q && res_status_q == ST_FULL))
		else $error("push onto a full store not rejected");

	a_reverse_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd.op == OP_REVERSE) |=> $stable(count_q))
		else $error("reverse changed the word count");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE && cmd_valid))
		else $error("request taken while busy or absent");

endmodule

>>> rtl/indexed_deque.sv
// ----------------------------------------------------------------------------
// indexed_deque: bounded deque of signed words with indexed access
// Push at either end, pop at the front, peek at either end, read at a
// position, remove at a position and reverse, each giving one result item.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ channel, one result item per request leaves on the
// m_ channel, in request order. A two-entry request queue sits in front of
// the execution unit, so requests are taken while a result waits.
// Push and error results go straight to the output register when a request
// reaches the execution unit; pop, peek and read pass through S_READ first,
// since the store's read port is registered. Remove at position p moves
// count-p-1 words, one per cycle; reverse swaps count/2 pairs through the
// single write port, one word of a pair in S_REV_A, the other in S_REV_B.
// Reset empties the deque at once; no clearing pass is needed, since only
// stored words are ever read. When m_tready is low the result is held, the
// execution unit waits, and s_tready drops once the request queue is full.
// ----------------------------------------------------------------------------
module indexed_deque
	import idq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// opcode[2:0], value[34:3], position[38:35], zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// data[31:0], count[36:32], status[38:37], zero pad
	output logic [OUT_W-1:0] m_tdata
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	idq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	idq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
